>>> rtl/fkht_pkg.sv
`default_nettype none
package fkht_pkg;

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_DUP      = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  localparam int unsigned REG_BUCKET_COUNT = 0;
  localparam logic [8:0] BUCKET_COUNT_RESET = 9'd256;

  typedef struct packed {
    logic [1:0]  command;
    logic [63:0] key_high;
    logic [63:0] key_low;
    logic [31:0] local_address;
    logic [15:0] local_port_in;
    logic [31:0] channel_address;
    logic [15:0] channel_port_in;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  bucket;
    logic [31:0] found_local_address;
    logic [15:0] found_local_port;
    logic [31:0] found_channel_address;
    logic [15:0] found_channel_port;
  } out_word_t;

endpackage
`default_nettype wire

>>> rtl/flow_key_hash_table_unit.sv
`default_nettype none
// Flow table with MAX_BUCKETS buckets of WAYS ways. Each request word
// goes through byte-serial hashing of its KEY_BYTES key bytes, a bit-serial
// remainder of the 32-bit hash by the bucket count, a handoff from the hash
// unit, one bucket-row read and a compare and write back that also loads
// the result register. The hash unit and the bucket memory handle one
// request at a time: the next word is taken only once the previous one has
// left the compare stage. A request whose result finds the previous word
// still unclaimed in the output register waits in the compare stage, which
// holds off the input. After reset the input stays not ready while the
// valid marks of all MAX_BUCKETS rows are cleared.
module flow_key_hash_table_unit #(
  parameter int unsigned MAX_BUCKETS = 256,
  parameter int unsigned WAYS        = 4,
  parameter int unsigned KEY_BYTES   = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire fkht_pkg::in_word_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output fkht_pkg::out_word_t       out_data,
  input  wire logic                 cfg_psel,
  input  wire logic                 cfg_penable,
  input  wire logic                 cfg_pwrite,
  input  wire logic [1:0]           cfg_paddr,
  input  wire logic [31:0]          cfg_pwdata,
  output logic [31:0]               cfg_prdata,
  output logic                      cfg_pready
);
  localparam int unsigned BKT_W = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int unsigned NHI = (KEY_BYTES >= 8) ? 8 : KEY_BYTES;
  localparam int unsigned NLO = (KEY_BYTES > 8) ? KEY_BYTES - 8 : 0;
  localparam logic [63:0] MASK_HI = (NHI == 0) ? 64'd0 :
                                    ~(64'hFFFF_FFFF_FFFF_FFFF >> (8 * NHI));
  localparam logic [63:0] MASK_LO = (NLO == 0) ? 64'd0 :
                                    ~(64'hFFFF_FFFF_FFFF_FFFF >> (8 * NLO));

  typedef enum logic [1:0] {S_IDLE, S_HASH, S_READ, S_EXEC} state_t;

  state_t               state_r;
  logic [8:0]           bcount_r;
  logic [1:0]           cmd_r;
  logic [63:0]          khi_r, klo_r;
  logic [95:0]          payload_r;
  logic [BKT_W-1:0]     bkt_r;
  logic [BKT_W:0]       modulus;
  logic                 hash_done;
  logic [BKT_W-1:0]     hash_bucket;
  logic                 table_ready;
  logic [WAYS-1:0]      rd_valid;
  logic [WAYS-1:0][223:0] rd_data;
  logic [WAYS-1:0]      hit_vec, hit_sel, free_sel;
  logic                 any_hit, any_free;
  logic [95:0]          hit_pay;
  logic                 wr_en, wr_set;
  logic [WAYS-1:0]      wr_way;
  logic [8:0]           nb;
  logic                 res_load;
  fkht_pkg::out_word_t  res;

  // Bucket count clamped to 1..MAX_BUCKETS.
  always_comb begin
    nb = (bcount_r == 9'd0) ? 9'd1 : bcount_r;
    if (32'(nb) > MAX_BUCKETS) modulus = (BKT_W + 1)'(MAX_BUCKETS);
    else modulus = (BKT_W + 1)'(nb);
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = {23'd0, bcount_r};

  always_ff @(posedge clk) begin
    if (!rst_n) bcount_r <= fkht_pkg::BUCKET_COUNT_RESET;
    else if (cfg_psel && cfg_penable && cfg_pwrite &&
             cfg_paddr == 2'(fkht_pkg::REG_BUCKET_COUNT * 4))
      bcount_r <= cfg_pwdata[8:0];
  end

  fkht_hash #(.KEY_BYTES(KEY_BYTES), .BKT_W(BKT_W)) u_hash (
    .clk(clk), .rst_n(rst_n),
    .start(in_valid && in_ready),
    .key_high(in_data.key_high & MASK_HI),
    .key_low(in_data.key_low & MASK_LO),
    .modulus(modulus),
    .done(hash_done),
    .bucket(hash_bucket)
  );

  always_comb begin
    hit_vec  = '0;
    hit_sel  = '0;
    free_sel = '0;
    any_hit  = 1'b0;
    any_free = 1'b0;
    hit_pay  = '0;
    for (int w = 0; w < WAYS; w++) begin
      hit_vec[w] = rd_valid[w] && rd_data[w][223:160] == khi_r &&
                   rd_data[w][159:96] == klo_r;
    end
    for (int w = 0; w < WAYS; w++) begin
      if (hit_vec[w] && !any_hit) begin
        hit_sel[w] = 1'b1;
        any_hit    = 1'b1;
        hit_pay    = rd_data[w][95:0];
      end
      if (!rd_valid[w] && !any_free) begin
        free_sel[w] = 1'b1;
        any_free    = 1'b1;
      end
    end
  end

  // The result register can take a new word when it is empty or being read.
  assign res_load = (state_r == S_EXEC) && (!out_valid || out_ready);

  always_comb begin
    wr_en  = 1'b0;
    wr_set = 1'b0;
    wr_way = '0;
    res    = '0;
    res.bucket = 8'(bkt_r);
    res.status = fkht_pkg::ST_NOTFOUND;
    case (fkht_pkg::cmd_t'(cmd_r))
      fkht_pkg::CMD_LOOKUP: begin
        if (any_hit) begin
          res.status                = fkht_pkg::ST_OK;
          res.found_local_address   = hit_pay[95:64];
          res.found_local_port      = hit_pay[63:48];
          res.found_channel_address = hit_pay[47:16];
          res.found_channel_port    = hit_pay[15:0];
        end
      end
      fkht_pkg::CMD_INSERT: begin
        if (any_hit) res.status = fkht_pkg::ST_DUP;
        else if (!any_free) res.status = fkht_pkg::ST_FULL;
        else begin
          res.status = fkht_pkg::ST_OK;
          wr_en  = res_load;
          wr_set = 1'b1;
          wr_way = free_sel;
        end
      end
      fkht_pkg::CMD_DELETE: begin
        if (any_hit) begin
          res.status = fkht_pkg::ST_OK;
          wr_en  = res_load;
          wr_way = hit_sel;
        end
      end
      default: res.status = fkht_pkg::ST_NOTFOUND;
    endcase
  end

  fkht_table #(.MAX_BUCKETS(MAX_BUCKETS), .WAYS(WAYS), .BKT_W(BKT_W)) u_table (
    .clk(clk), .rst_n(rst_n),
    .clear_done(table_ready),
    .rd_en(state_r == S_READ),
    .rd_bucket(bkt_r),
    .rd_valid(rd_valid),
    .rd_data(rd_data),
    .wr_en(wr_en),
    .wr_bucket(bkt_r),
    .wr_way(wr_way),
    .wr_set(wr_set),
    .wr_data({khi_r, klo_r, payload_r})
  );

  assign in_ready = (state_r == S_IDLE) && table_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (res_load) begin
        out_data  <= res;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            cmd_r     <= in_data.command;
            khi_r     <= in_data.key_high & MASK_HI;
            klo_r     <= in_data.key_low & MASK_LO;
            payload_r <= {in_data.local_address, in_data.local_port_in,
                          in_data.channel_address, in_data.channel_port_in};
            state_r   <= S_HASH;
          end
        end
        S_HASH: begin
          if (hash_done) begin
            bkt_r   <= hash_bucket;
            state_r <= S_READ;
          end
        end
        S_READ: state_r <= S_EXEC;
        S_EXEC: begin
          // Wait here only while the previous word is still unclaimed.
          if (res_load) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> rtl/fkht_hash.sv
`default_nettype none
// Hash of the key, one byte per cycle, then a restoring remainder by the
// bucket count, one quotient bit per cycle.
module fkht_hash #(
  parameter int unsigned KEY_BYTES = 16,
  parameter int unsigned BKT_W     = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [63:0]       key_high,
  input  wire logic [63:0]       key_low,
  input  wire logic [BKT_W:0]    modulus,
  output logic                   done,
  output logic [BKT_W-1:0]       bucket
);
  localparam int unsigned CNT_W = 6;

  typedef enum logic [1:0] {S_IDLE, S_HASH, S_MOD, S_DONE} state_t;

  state_t          state_r;
  logic [CNT_W-1:0] cnt_r;
  logic [127:0]    key_r;
  logic [31:0]     h_r;
  logic [BKT_W:0]  rem_r;
  logic [BKT_W:0]  mod_r;
  logic [BKT_W+1:0] trial;
  logic [31:0]     h_nxt;

  always_comb begin
    h_nxt = {24'd0, key_r[127:120]} + (h_r << 5) - h_r;
    trial = {rem_r, h_r[31]} - {1'b0, mod_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (start) begin
            key_r   <= {key_high, key_low};
            h_r     <= '0;
            mod_r   <= modulus;
            cnt_r   <= '0;
            state_r <= S_HASH;
          end
        end
        S_HASH: begin
          h_r   <= h_nxt;
          key_r <= key_r << 8;
          if (cnt_r == CNT_W'(KEY_BYTES - 1)) begin
            cnt_r   <= '0;
            rem_r   <= '0;
            state_r <= S_MOD;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_MOD: begin
          // Remainder never exceeds modulus-1, so trial fits one extra bit.
          if (!trial[BKT_W+1]) rem_r <= trial[BKT_W:0];
          else rem_r <= {rem_r[BKT_W-1:0], h_r[31]};
          h_r <= h_r << 1;
          if (cnt_r == CNT_W'(31)) state_r <= S_DONE;
          cnt_r <= cnt_r + 1'b1;
        end
        S_DONE: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign done   = (state_r == S_DONE);
  assign bucket = rem_r[BKT_W-1:0];
endmodule
`default_nettype wire

>>> rtl/fkht_table.sv
`default_nettype none
// Bucket store: one memory row per bucket holds all ways, and a second
// memory holds the valid marks of each row. After reset the valid memory
// is cleared one row per cycle, all MAX_BUCKETS rows in turn, and clear_done
// stays low until that pass has finished.
module fkht_table #(
  parameter int unsigned MAX_BUCKETS = 256,
  parameter int unsigned WAYS        = 4,
  parameter int unsigned BKT_W       = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  output logic                      clear_done,
  input  wire logic                 rd_en,
  input  wire logic [BKT_W-1:0]     rd_bucket,
  output logic [WAYS-1:0]           rd_valid,
  output logic [WAYS-1:0][223:0]    rd_data,
  input  wire logic                 wr_en,
  input  wire logic [BKT_W-1:0]     wr_bucket,
  input  wire logic [WAYS-1:0]      wr_way,
  input  wire logic                 wr_set,
  input  wire logic [223:0]         wr_data
);
  logic [WAYS-1:0][223:0] mem [MAX_BUCKETS];
  logic [WAYS-1:0]        valid_mem [MAX_BUCKETS];
  logic                   clearing_r;
  logic [BKT_W-1:0]       clr_idx_r;
  logic [WAYS-1:0]        valid_row;

  // The row written back is the row read for this request with one way changed.
  always_comb begin
    valid_row = rd_valid & ~wr_way;
    if (wr_set) valid_row = valid_row | wr_way;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= mem[rd_bucket];
    if (wr_en && wr_set) begin
      for (int w = 0; w < WAYS; w++) begin
        if (wr_way[w]) mem[wr_bucket][w] <= wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clearing_r) begin
      if (clr_idx_r == BKT_W'(MAX_BUCKETS - 1)) clearing_r <= 1'b0;
      clr_idx_r <= clr_idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing_r) valid_mem[clr_idx_r] <= '0;
    else if (wr_en) valid_mem[wr_bucket] <= valid_row;
    if (rd_en) rd_valid <= valid_mem[rd_bucket];
  end

  assign clear_done = !clearing_r;
endmodule
`default_nettype wire
